// File: rtl/rmi_pkg.sv
// rmi_pkg: shared widths, register codes and the cell payload type
// used by rmi_div_cell and row_major_index_to_coords_core; no dependencies
`default_nettype none
package rmi_pkg;

  localparam int unsigned NUM_DIMS  = 4;
  localparam int unsigned IDX_W     = 31;
  localparam int unsigned DIM_W     = 16;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned DSEL_W    = $clog2(NUM_DIMS);
  localparam int unsigned NUM_CELLS = NUM_DIMS * IDX_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACTIVE_RANK = 3'd0,
    REG_DIM_SIZE_0  = 3'd1,
    REG_DIM_SIZE_1  = 3'd2,
    REG_DIM_SIZE_2  = 3'd3,
    REG_DIM_SIZE_3  = 3'd4
  } rmi_reg_t;

  typedef struct packed {
    logic                               valid;
    logic [DIM_W-1:0]                   part;
    logic [IDX_W-1:0]                   work;
    logic [NUM_DIMS-1:0][DIM_W-1:0]     coord;
  } rmi_cell_t;

endpackage
`default_nettype wire

// File: rtl/rmi_div_cell.sv
// rmi_div_cell: one restoring division step, registered
// depends on rmi_pkg
`default_nettype none
module rmi_div_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [rmi_pkg::DIM_W-1:0]   divisor,
  input  logic                        step_last,
  input  logic [rmi_pkg::DSEL_W-1:0]  dim_sel,
  input  rmi_pkg::rmi_cell_t          cell_in,
  output rmi_pkg::rmi_cell_t          cell_out
);
  import rmi_pkg::*;

  logic [DIM_W:0]   trial;
  logic             ge;
  logic [DIM_W:0]   diff;
  logic [DIM_W-1:0] part_new;
  rmi_cell_t        cell_nxt;
  logic             valid_r;
  rmi_cell_t        data_r;

  always_comb begin
    trial    = {cell_in.part, cell_in.work[IDX_W-1]};
    ge       = (trial >= {1'b0, divisor});
    diff     = trial - {1'b0, divisor};
    part_new = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
    cell_nxt = cell_in;
    cell_nxt.work = {cell_in.work[IDX_W-2:0], ge};
    if (step_last) begin
      // remainder becomes the coordinate, quotient carries on
      cell_nxt.coord[dim_sel] = part_new;
      cell_nxt.part           = '0;
    end else begin
      cell_nxt.part = part_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cell_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= cell_nxt;
  end

  always_comb begin
    cell_out       = data_r;
    cell_out.valid = valid_r;
  end

endmodule
`default_nettype wire

// File: rtl/row_major_index_to_coords_core.sv
// row_major_index_to_coords_core: top level, config registers and cell chain
// depends on rmi_pkg and rmi_div_cell
//
//  channel   ports                                   handshake
//  input     start, busy, in_linear_index            start & !busy
//  result    out_valid, out_coord_0..3, out_in_range one-cycle strobe
//  config    cfg_we, cfg_index, cfg_wdata            cfg_we, no wait
//
// one transaction per cycle; each runs through the registered chain of
// one-bit division cells, 31 per dimension, innermost dimension first
// busy is always low: every cell advances every cycle
// synchronous active-low reset clears the valid bits and sets the config registers to full rank and sizes of one
// the receiver cannot stall, results leave the chain on the cycle they finish
`default_nettype none
module row_major_index_to_coords_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rmi_pkg::IDX_W-1:0]      in_linear_index,
  output logic                           out_valid,
  output logic [rmi_pkg::DIM_W-1:0]      out_coord_0,
  output logic [rmi_pkg::DIM_W-1:0]      out_coord_1,
  output logic [rmi_pkg::DIM_W-1:0]      out_coord_2,
  output logic [rmi_pkg::DIM_W-1:0]      out_coord_3,
  output logic                           out_in_range,
  input  logic                           cfg_we,
  input  logic [rmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rmi_pkg::DIM_W-1:0]      cfg_wdata
);
  import rmi_pkg::*;

  logic [RANK_W-1:0]               rank_r;
  logic [NUM_DIMS-1:0][DIM_W-1:0]  size_r;
  logic [RANK_W-1:0]               rank_eff;
  logic [NUM_DIMS-1:0][DIM_W-1:0]  div_eff;
  rmi_cell_t                       chain [NUM_CELLS+1];

  // config writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rank_r <= RANK_W'(NUM_DIMS);
      for (int i = 0; i < NUM_DIMS; i++) begin
        size_r[i] <= DIM_W'(1);
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_RANK: rank_r    <= cfg_wdata[RANK_W-1:0];
        REG_DIM_SIZE_0:  size_r[0] <= cfg_wdata;
        REG_DIM_SIZE_1:  size_r[1] <= cfg_wdata;
        REG_DIM_SIZE_2:  size_r[2] <= cfg_wdata;
        REG_DIM_SIZE_3:  size_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // rank zero acts as one, above max saturates; inactive or zero sizes divide by one,
  // which leaves the index untouched and gives a zero coordinate
  always_comb begin
    if (rank_r == '0) begin
      rank_eff = RANK_W'(1);
    end else if (rank_r > RANK_W'(NUM_DIMS)) begin
      rank_eff = RANK_W'(NUM_DIMS);
    end else begin
      rank_eff = rank_r;
    end
    for (int i = 0; i < NUM_DIMS; i++) begin
      if ((RANK_W'(i) >= rank_eff) || (size_r[i] == '0)) begin
        div_eff[i] = DIM_W'(1);
      end else begin
        div_eff[i] = size_r[i];
      end
    end
  end

  assign busy = 1'b0;

  always_comb begin
    chain[0]       = '0;
    chain[0].valid = start;
    chain[0].work  = in_linear_index;
  end

  // innermost dimension first, IDX_W steps per dimension
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    localparam int unsigned DIM  = NUM_DIMS - 1 - (k / IDX_W);
    localparam bit          LAST = ((k % IDX_W) == (IDX_W - 1));
    rmi_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .divisor  (div_eff[DIM]),
      .step_last(LAST),
      .dim_sel  (DSEL_W'(DIM)),
      .cell_in  (chain[k]),
      .cell_out (chain[k+1])
    );
  end

  assign out_valid    = chain[NUM_CELLS].valid;
  assign out_coord_0  = chain[NUM_CELLS].coord[0];
  assign out_coord_1  = chain[NUM_CELLS].coord[1];
  assign out_coord_2  = chain[NUM_CELLS].coord[2];
  assign out_coord_3  = chain[NUM_CELLS].coord[3];
  // quotient left after all sizes is zero exactly when index is in range
  assign out_in_range = (chain[NUM_CELLS].work == '0);

  a_no_busy: assert property (@(posedge clk) !busy)
    else $error("busy raised");
  a_coord0_lt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coord_0 < div_eff[0]))
    else $error("outer coordinate not reduced");
  a_coord3_lt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_coord_3 < div_eff[3]))
    else $error("inner coordinate not reduced");

endmodule
`default_nettype wire
